>>> rtl/fdd_pkg.sv
`timescale 1ns / 1ps
// Package for the finite-difference derivative block.
// Holds the transfer payload types, status and order codes, the sequencer states and the saturation limits.
// Has no dependencies.
package fdd_pkg;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [31:0] sample_value;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic [32:0]        mid_time_doubled;
        logic signed [47:0] derivative;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_RND,
        S_FIN
    } t_state;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_INC = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [1:0] ORDER_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_SECOND = 2'd2;

    localparam logic [47:0] DER_MAX_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] DER_MAX_NEG = 48'h8000_0000_0000;

endpackage

>>> rtl/finite_difference_derivative_top.sv
`timescale 1ns / 1ps
// Top level of the finite-difference derivative block: history, sequencer and divider.
// Depends on fdd_pkg.
//
// The block accepts one timestamped sample per transfer and, once enough history is
// held, returns a first or second derivative in signed fixed point with FRAC_BITS
// fraction bits, rounded to nearest and saturated to 48 bits. A sample that gives no
// result only updates the history. A sample whose timestamps do not increase goes
// straight to the output step and yields a zero derivative with status ST_NOT_INC.
// Otherwise the result passes through a multiply step for the squared span, a
// restoring divider that forms one quotient bit per cycle, a rounding step and an
// output step. The output step waits while the output register still holds an
// earlier result. The input side is ready again in the cycle after the result is
// loaded into the output register, so a waiting result does not block the next
// sample.
module finite_difference_derivative_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fdd_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fdd_pkg::t_out_item o_out_data
);
    import fdd_pkg::*;

    localparam int NUMW = 36 + FRAC_BITS + 1;
    localparam int CNTW = $clog2(NUMW);
    localparam int MAGW = (NUMW > 49) ? NUMW : 49;

    t_state r_state, n_state;
    logic [1:0]  r_order, n_order;
    logic [1:0]  r_hist, n_hist;
    logic [31:0] r_past_time [2];
    logic [31:0] n_past_time [2];
    logic signed [31:0] r_past_value [2];
    logic signed [31:0] n_past_value [2];
    logic [32:0] r_mid, n_mid;
    logic        r_neg, n_neg;
    logic [35:0] r_num, n_num;
    logic [31:0] r_span, n_span;
    logic        r_second, n_second;
    logic        r_notinc, n_notinc;
    logic [63:0] r_den, n_den;
    logic [63:0] r_rem, n_rem;
    logic [NUMW-1:0] r_quo, n_quo;
    logic [NUMW-1:0] r_mag, n_mag;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;

    logic        w_second;
    logic [1:0]  w_hist;
    logic        w_has_result;
    logic        w_inc;
    logic [31:0] w_t, w_t0;
    logic signed [34:0] w_y, w_y1, w_y0, w_d;
    logic [34:0] w_abs;
    logic [35:0] w_num;
    logic [64:0] w_trial;
    logic        w_ge;
    logic [63:0] w_sq;
    logic [MAGW-1:0] w_mag_ext, w_lim;
    logic        w_sat;
    logic [47:0] w_mag48;

    assign w_second     = (r_order == ORDER_SECOND);
    assign w_hist       = i_in_data.restart ? 2'd0 : r_hist;
    assign w_has_result = w_second ? (w_hist == 2'd2) : (w_hist != 2'd0);
    assign w_t          = i_in_data.sample_time;
    assign w_t0         = w_second ? r_past_time[0] : r_past_time[1];
    assign w_inc        = w_second ? ((r_past_time[1] > r_past_time[0]) && (w_t > r_past_time[1]))
                                   : (w_t > r_past_time[1]);
    assign w_y          = 35'(i_in_data.sample_value);
    assign w_y1         = 35'(r_past_value[1]);
    assign w_y0         = 35'(r_past_value[0]);
    assign w_d          = w_second ? (w_y - (w_y1 <<< 1) + w_y0) : (w_y - w_y1);
    assign w_abs        = w_d[34] ? 35'(-w_d) : 35'(w_d);
    assign w_num        = w_second ? {w_abs[33:0], 2'b00} : 36'(w_abs);

    assign w_sq         = r_span * r_span;

    assign w_trial      = {r_rem, r_quo[NUMW-1]};
    assign w_ge         = (w_trial >= {1'b0, r_den});

    assign w_mag_ext    = MAGW'(r_mag);
    assign w_lim        = r_neg ? MAGW'(DER_MAX_NEG) : MAGW'(DER_MAX_POS);
    assign w_sat        = (w_mag_ext > w_lim);
    assign w_mag48      = w_sat ? w_lim[47:0] : w_mag_ext[47:0];

    always_comb begin
        n_state      = r_state;
        n_order      = r_order;
        n_hist       = r_hist;
        n_past_time  = r_past_time;
        n_past_value = r_past_value;
        n_mid        = r_mid;
        n_neg        = r_neg;
        n_num        = r_num;
        n_span       = r_span;
        n_second     = r_second;
        n_notinc     = r_notinc;
        n_den        = r_den;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_mag        = r_mag;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (i_cfg_we) begin
            n_order = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_past_time[0]  = r_past_time[1];
                    n_past_value[0] = r_past_value[1];
                    n_past_time[1]  = w_t;
                    n_past_value[1] = i_in_data.sample_value;
                    n_hist          = (w_hist == 2'd2) ? 2'd2 : w_hist + 2'd1;
                    if (w_has_result) begin
                        n_mid    = 33'(w_t0) + 33'(w_t);
                        n_neg    = w_d[34];
                        n_num    = w_num;
                        n_span   = w_t - w_t0;
                        n_second = w_second;
                        n_notinc = !w_inc;
                        n_state  = w_inc ? S_MUL : S_FIN;
                    end
                end
            end
            S_MUL: begin
                n_den   = r_second ? w_sq : 64'(r_span);
                n_quo   = {r_num, (FRAC_BITS + 1)'(0)};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_ge ? 64'(w_trial - {1'b0, r_den}) : w_trial[63:0];
                n_quo = {r_quo[NUMW-2:0], w_ge};
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NUMW - 1)) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_mag   = {1'b0, r_quo[NUMW-1:1]} + NUMW'(r_quo[0]);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.mid_time_doubled = r_mid;
                    if (r_notinc) begin
                        n_out_data.derivative = '0;
                        n_out_data.status     = ST_NOT_INC;
                    end else begin
                        n_out_data.derivative = r_neg ? $signed(-w_mag48) : $signed(w_mag48);
                        n_out_data.status     = w_sat ? ST_SAT : ST_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_order         <= ORDER_FIRST;
            r_hist          <= 2'd0;
            r_past_time[0]  <= '0;
            r_past_time[1]  <= '0;
            r_past_value[0] <= '0;
            r_past_value[1] <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_order      <= n_order;
            r_hist       <= n_hist;
            r_past_time  <= n_past_time;
            r_past_value <= n_past_value;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid      <= n_mid;
        r_neg      <= n_neg;
        r_num      <= n_num;
        r_span     <= n_span;
        r_second   <= n_second;
        r_notinc   <= n_notinc;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_mag      <= n_mag;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/fdd_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the finite-difference derivative block, bound to the top level.
// Depends on fdd_pkg and finite_difference_derivative_top.
module fdd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fdd_pkg::t_out_item o_out_data
);
    import fdd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result dropped before its transfer.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("Result changed while stalled.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_NOT_INC
                         || o_out_data.status == ST_SAT))
        else $error("Unknown status code.");

    a_notinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NOT_INC |-> o_out_data.derivative == '0)
        else $error("Non-increasing time with a nonzero derivative.");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_SAT |->
            (o_out_data.derivative == DER_MAX_POS || o_out_data.derivative == DER_MAX_NEG))
        else $error("Saturated status without a limit value.");

endmodule

bind finite_difference_derivative_top fdd_checker u_fdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
